/* sv/epq_pkg.sv */
// ----------------------------------------------------------------------------
// epq_pkg
// Shared types and codes of the event priority queue: beat layouts, mode and
// status codes, the stored entry and the control word sent to every cell.
// ----------------------------------------------------------------------------
package epq_pkg;

    // width of the count fields reported in a result beat
    localparam int unsigned CNT_OUT_W = 5;

    typedef enum logic [1:0] {
        MD_SCHED    = 2'd0,
        MD_DEL_ID   = 2'd1,
        MD_DEL_NAME = 2'd2,
        MD_POP      = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_PAST  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        t_mode              mode;
        logic [15:0]        event_id;
        logic [15:0]        name_tag;
        logic [63:0]        event_tick;
        logic signed [7:0]  event_priority;
    } t_in_beat;

    typedef struct packed {
        t_status                status;
        logic                   popped_valid;
        logic [15:0]            popped_id;
        logic [15:0]            popped_name;
        logic [63:0]            popped_tick;
        logic signed [7:0]      popped_priority;
        logic [CNT_OUT_W-1:0]   removed_count;
        logic [63:0]            current_tick;
        logic [CNT_OUT_W-1:0]   entry_count;
        logic                   queue_empty;
    } t_out_beat;

    // one stored event
    typedef struct packed {
        logic [63:0]        tick;
        logic signed [7:0]  prio;
        logic [15:0]        id;
        logic [15:0]        name;
    } t_entry;

    // control word broadcast to all cells
    typedef struct packed {
        logic        ins;       // insert the new entry in sorted place
        logic        shl;       // shift entries left from the first hit on
        logic        head;      // hit starts at the head (pop)
        logic        by_name;   // match on name tag instead of id
        logic [15:0] key;
        t_entry      ent;
    } t_cell_ctl;

endpackage

/* sv/epq_if.sv */
// ----------------------------------------------------------------------------
// epq_if
// Valid/ready channels of the event priority queue: request and result beats.
// ----------------------------------------------------------------------------
interface epq_in_if;
    logic              valid;
    logic              ready;
    epq_pkg::t_in_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface epq_out_if;
    logic               valid;
    logic               ready;
    epq_pkg::t_out_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/event_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// event_priority_queue_unit
// Sorted event queue for a discrete-event simulator, built as a chain of
// slot cells kept in tick order, highest priority first within a tick.
// ----------------------------------------------------------------------------
// One request is taken at a time. A schedule or a pop goes through accept, one
// cell update and the result load; the load waits while the output register
// is still held. A removal by id or name tag repeats the cell update once per
// entry removed: the cell chain closes one gap per cycle by shifting the
// entries after the first match one slot toward the head. A finished result
// waits in the output register while the next request is accepted.
module event_priority_queue_unit #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    epq_in_if.sink     i_in,
    epq_out_if.source  o_out
);
    import epq_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state          r_state;
    t_state          n_state;
    t_in_beat        r_item;
    t_in_beat        n_item;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic [CW-1:0]   r_removed;
    logic [CW-1:0]   n_removed;
    t_status         r_status;
    t_status         n_status;
    logic            r_pop_vld;
    logic            n_pop_vld;
    t_entry          r_pop;
    t_entry          n_pop;
    logic [63:0]     r_now;
    logic [63:0]     n_now;
    t_out_beat       r_out;
    t_out_beat       n_out;
    logic            r_out_vld;
    logic            n_out_vld;
    t_cell_ctl       w_ctl;
    logic            w_accept;
    logic            w_load;
    logic [CW+4:0]   w_cnt_ext;
    logic [CW+4:0]   w_rem_ext;

    logic            w_vld    [CAPACITY];
    t_entry          w_ent    [CAPACITY];
    logic            w_before [CAPACITY];
    logic            w_hit    [CAPACITY];
    logic            w_lft_vld    [CAPACITY];
    t_entry          w_lft_ent    [CAPACITY];
    logic            w_lft_before [CAPACITY];
    logic            w_rgt_vld    [CAPACITY];
    t_entry          w_rgt_ent    [CAPACITY];
    logic            w_hit_in     [CAPACITY];

    // cell chain with neighbor hookup
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        if (gi == 0) begin : g_first
            assign w_lft_vld[gi]    = 1'b0;
            assign w_lft_ent[gi]    = '0;
            assign w_lft_before[gi] = 1'b0;
            assign w_hit_in[gi]     = w_ctl.head;
        end else begin : g_mid
            assign w_lft_vld[gi]    = w_vld[gi-1];
            assign w_lft_ent[gi]    = w_ent[gi-1];
            assign w_lft_before[gi] = w_before[gi-1];
            assign w_hit_in[gi]     = w_hit[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_last
            assign w_rgt_vld[gi] = 1'b0;
            assign w_rgt_ent[gi] = '0;
        end else begin : g_inner
            assign w_rgt_vld[gi] = w_vld[gi+1];
            assign w_rgt_ent[gi] = w_ent[gi+1];
        end

        epq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_lft_vld    (w_lft_vld[gi]),
            .i_lft_ent    (w_lft_ent[gi]),
            .i_lft_before (w_lft_before[gi]),
            .i_rgt_vld    (w_rgt_vld[gi]),
            .i_rgt_ent    (w_rgt_ent[gi]),
            .i_hit        (w_hit_in[gi]),
            .o_before     (w_before[gi]),
            .o_hit        (w_hit[gi]),
            .o_vld        (w_vld[gi]),
            .o_ent        (w_ent[gi])
        );
    end

    // handshakes
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && (r_state == S_IDLE);
    assign w_load      = (r_state == S_DONE) && (!r_out_vld || o_out.ready);
    assign o_out.valid   = r_out_vld;
    assign o_out.payload = r_out;

    // counts reported in their low bits
    assign w_cnt_ext = {5'd0, n_count};
    assign w_rem_ext = {5'd0, r_removed};

    // sequencer and cell control
    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_count   = r_count;
        n_removed = r_removed;
        n_status  = r_status;
        n_pop_vld = r_pop_vld;
        n_pop     = r_pop;
        n_now     = r_now;
        n_out     = r_out;

        w_ctl          = '0;
        w_ctl.by_name  = (r_item.mode == MD_DEL_NAME);
        w_ctl.key      = w_ctl.by_name ? r_item.name_tag : r_item.event_id;
        w_ctl.ent.tick = r_item.event_tick;
        w_ctl.ent.prio = r_item.event_priority;
        w_ctl.ent.id   = r_item.event_id;
        w_ctl.ent.name = r_item.name_tag;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_item    = i_in.payload;
                    n_status  = ST_OK;
                    n_removed = '0;
                    n_pop_vld = 1'b0;
                    n_pop     = '0;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_item.mode)
                    MD_SCHED: begin
                        if (r_item.event_tick < r_now) begin
                            n_status = ST_PAST;
                        end else if (r_count == CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else begin
                            w_ctl.ins = 1'b1;
                            n_count   = r_count + 1'b1;
                        end
                        n_state = S_DONE;
                    end
                    MD_DEL_ID, MD_DEL_NAME: begin
                        // one match leaves the chain per cycle
                        if (w_hit[CAPACITY-1]) begin
                            w_ctl.shl = 1'b1;
                            n_count   = r_count - 1'b1;
                            n_removed = r_removed + 1'b1;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    MD_POP: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            w_ctl.head = 1'b1;
                            w_ctl.shl  = 1'b1;
                            n_pop_vld  = 1'b1;
                            n_pop      = w_ent[0];
                            n_count    = r_count - 1'b1;
                            n_removed  = CW'(1);
                        end
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                if (w_load) begin
                    if (r_count != '0) begin
                        n_now = w_ent[0].tick;
                    end
                    n_out.status          = r_status;
                    n_out.popped_valid    = r_pop_vld;
                    n_out.popped_id       = r_pop.id;
                    n_out.popped_name     = r_pop.name;
                    n_out.popped_tick     = r_pop.tick;
                    n_out.popped_priority = r_pop.prio;
                    n_out.removed_count   = w_rem_ext[CNT_OUT_W-1:0];
                    n_out.current_tick    = n_now;
                    n_out.entry_count     = w_cnt_ext[CNT_OUT_W-1:0];
                    n_out.queue_empty     = (r_count == '0);
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // output register valid
        if (w_load) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_now     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_now     <= n_now;
            r_out_vld <= n_out_vld;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_removed <= n_removed;
        r_status  <= n_status;
        r_pop_vld <= n_pop_vld;
        r_pop     <= n_pop;
        r_out     <= n_out;
    end

`ifndef SYNTHESIS
    logic [CAPACITY-1:0] a_vld_vec;
    for (genvar ga = 0; ga < CAPACITY; ga++) begin : g_avld
        assign a_vld_vec[ga] = w_vld[ga];
    end

    // entry count never passes the number of cells
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // between requests the occupied cells match the entry count
    a_count_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(a_vld_vec) == 32'(r_count)))
        else $error("occupied cells disagree with entry count");

    // the head never comes after its successor in tick order
    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && w_vld[0] && w_vld[1]) |-> (w_ent[0].tick <= w_ent[1].tick))
        else $error("head entry out of tick order");
`endif

endmodule

/* sv/epq_cell.sv */
// ----------------------------------------------------------------------------
// epq_cell
// One slot of the sorted event chain. Takes the new entry or its left
// neighbor on insert, and its right neighbor when a removal passes it.
// ----------------------------------------------------------------------------
module epq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  epq_pkg::t_cell_ctl i_ctl,
    input  logic               i_lft_vld,
    input  epq_pkg::t_entry    i_lft_ent,
    input  logic               i_lft_before,
    input  logic               i_rgt_vld,
    input  epq_pkg::t_entry    i_rgt_ent,
    input  logic               i_hit,
    output logic               o_before,
    output logic               o_hit,
    output logic               o_vld,
    output epq_pkg::t_entry    o_ent
);
    import epq_pkg::*;

    logic   r_vld;
    logic   n_vld;
    t_entry r_ent;
    t_entry n_ent;
    logic   w_match;

    // new entry goes ahead of this slot: empty, later tick, or same tick and not higher priority
    assign o_before = !r_vld
                   || (r_ent.tick > i_ctl.ent.tick)
                   || ((r_ent.tick == i_ctl.ent.tick) && (r_ent.prio <= i_ctl.ent.prio));

    // key match, rippled to the right as a hit-seen flag
    assign w_match = r_vld && !i_ctl.head
                  && (i_ctl.by_name ? (r_ent.name == i_ctl.key) : (r_ent.id == i_ctl.key));
    assign o_hit   = i_hit || w_match;

    // next slot contents
    always_comb begin
        n_vld = r_vld;
        n_ent = r_ent;
        if (i_ctl.ins && o_before) begin
            if (i_lft_before) begin
                n_vld = i_lft_vld;
                n_ent = i_lft_ent;
            end else begin
                n_vld = 1'b1;
                n_ent = i_ctl.ent;
            end
        end else if (i_ctl.shl && o_hit) begin
            n_vld = i_rgt_vld;
            n_ent = i_rgt_ent;
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_vld = r_vld;
    assign o_ent = r_ent;

endmodule

/* test/tb_event_priority_queue_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_event_priority_queue_unit
// Self-checking bench for the sorted event queue. Request beats come from a
// backlog that is filled first with hand-picked cases (pop on empty, ties in
// tick and priority, a tick in the past, a full queue, removals by id and by
// name tag) and then with random batches. A shadow copy of the queue works
// out each result beat on accept. Result beats are checked field by field
// in order. Both channels stall at random, except for one calm stretch.
// ----------------------------------------------------------------------------
module tb_event_priority_queue_unit;
    import epq_pkg::*;

    localparam int unsigned CAPACITY   = 16;
    localparam int          RAND_ITEMS = 850;
    localparam int          MAX_CYCLES = 200000;
    localparam int          DRAIN_WAIT = 25;

    logic i_clk;
    logic i_rst_n;

    epq_in_if  req_ch ();
    epq_out_if res_ch ();

    event_priority_queue_unit #(
        .CAPACITY(CAPACITY)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_ch),
        .o_out  (res_ch)
    );

    // shadow copy of the queue contents
    t_entry      shadow_slots [CAPACITY] = '{default: '0};
    int          shadow_count = 0;
    logic [63:0] shadow_now = '0;

    t_in_beat  req_backlog[$];
    t_out_beat result_due_q[$];

    int  beats_taken;
    int  results_seen;
    int  mismatches = 0;
    int  cycles = 0;
    logic quiet_span;

    assign quiet_span = (beats_taken >= 300) && (beats_taken < 520);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // apply one request to the shadow queue and return the result beat
    function automatic t_out_beat next_queue_result(t_in_beat b);
        t_out_beat r;
        int pos;
        int w;
        int gone;
        logic drop;
        r = '0;
        r.status = ST_OK;
        gone = 0;
        case (b.mode)
            MD_SCHED: begin
                if (b.event_tick < shadow_now) begin
                    r.status = ST_PAST;
                end else if (shadow_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < shadow_count &&
                           (shadow_slots[pos].tick < b.event_tick ||
                            (shadow_slots[pos].tick == b.event_tick &&
                             $signed(shadow_slots[pos].prio) > $signed(b.event_priority))))
                        pos++;
                    for (int i = shadow_count; i > pos; i--)
                        shadow_slots[i] = shadow_slots[i-1];
                    shadow_slots[pos].tick = b.event_tick;
                    shadow_slots[pos].prio = b.event_priority;
                    shadow_slots[pos].id   = b.event_id;
                    shadow_slots[pos].name = b.name_tag;
                    shadow_count++;
                end
            end
            default: begin
                if (b.mode == MD_POP && shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (b.mode == MD_POP) begin
                        r.popped_valid    = 1'b1;
                        r.popped_id       = shadow_slots[0].id;
                        r.popped_name     = shadow_slots[0].name;
                        r.popped_tick     = shadow_slots[0].tick;
                        r.popped_priority = shadow_slots[0].prio;
                    end
                    // pack the surviving entries toward the head
                    w = 0;
                    for (int i = 0; i < shadow_count; i++) begin
                        if (b.mode == MD_POP)
                            drop = (i == 0);
                        else if (b.mode == MD_DEL_NAME)
                            drop = (shadow_slots[i].name == b.name_tag);
                        else
                            drop = (shadow_slots[i].id == b.event_id);
                        if (drop) begin
                            gone++;
                        end else begin
                            shadow_slots[w] = shadow_slots[i];
                            w++;
                        end
                    end
                    shadow_count = w;
                end
            end
        endcase
        // current tick follows the head, held while empty
        if (shadow_count > 0)
            shadow_now = shadow_slots[0].tick;
        r.removed_count = CNT_OUT_W'(gone);
        r.current_tick  = shadow_now;
        r.entry_count   = CNT_OUT_W'(shadow_count);
        r.queue_empty   = (shadow_count == 0);
        return r;
    endfunction

    task automatic add_req(t_mode m, logic [15:0] id, logic [15:0] nm,
                           logic [63:0] tk, logic signed [7:0] pr);
        t_in_beat b;
        b.mode           = m;
        b.event_id       = id;
        b.name_tag       = nm;
        b.event_tick     = tk;
        b.event_priority = pr;
        req_backlog.push_back(b);
    endtask

    task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d %s: expected %h, got %h",
                         results_seen, fname, want, got);
        end
    endtask

    // request driver: holds a beat until taken, idles at random otherwise
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid   <= 1'b0;
            req_ch.payload <= '0;
            beats_taken    <= 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                result_due_q.push_back(next_queue_result(req_backlog.pop_front()));
                beats_taken <= beats_taken + 1;
            end
            if (req_ch.valid && !req_ch.ready) begin
                // beat still pending, keep it on the bus
            end else if (req_backlog.size() != 0 &&
                         (quiet_span || $urandom_range(0, 99) >= 27)) begin
                req_ch.valid   <= 1'b1;
                req_ch.payload <= req_backlog[0];
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor: random back-pressure, in-order field check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            results_seen <= 0;
        end else begin
            res_ch.ready <= quiet_span || ($urandom_range(0, 99) >= 27);
            if (res_ch.valid && res_ch.ready) begin
                if (result_due_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with nothing outstanding", results_seen);
                end else begin
                    t_out_beat want;
                    t_out_beat got;
                    want = result_due_q.pop_front();
                    got  = res_ch.payload;
                    check_field("status", want.status, got.status);
                    check_field("popped_valid", want.popped_valid, got.popped_valid);
                    check_field("popped_id", want.popped_id, got.popped_id);
                    check_field("popped_name", want.popped_name, got.popped_name);
                    check_field("popped_tick", want.popped_tick, got.popped_tick);
                    check_field("popped_priority", want.popped_priority,
                                got.popped_priority);
                    check_field("removed_count", want.removed_count, got.removed_count);
                    check_field("current_tick", want.current_tick, got.current_tick);
                    check_field("entry_count", want.entry_count, got.entry_count);
                    check_field("queue_empty", want.queue_empty, got.queue_empty);
                end
                results_seen <= results_seen + 1;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == MAX_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        int sent;
        int batch;
        int est;
        int pick;
        logic [63:0] base;
        logic [63:0] tk;
        logic [15:0] id;
        logic [15:0] nm;
        logic signed [7:0] pr;
        t_mode m;

        i_rst_n = 1'b0;

        // hand-picked cases
        add_req(MD_POP, 16'h0000, 16'h0000, 64'd0, 8'sd0);
        add_req(MD_DEL_ID, 16'h0000, 16'h0000, 64'd0, 8'sd0);
        add_req(MD_SCHED, 16'h0001, 16'hFFFF, 64'd5, -8'sd128);
        add_req(MD_SCHED, 16'h0002, 16'h0000, 64'd5, 8'sd127);
        // same tick and priority: goes ahead of the stored one
        add_req(MD_SCHED, 16'h0003, 16'h0000, 64'd5, 8'sd127);
        add_req(MD_SCHED, 16'hFFFF, 16'h5A5A, {64{1'b1}}, 8'sd0);
        // tick in the past
        add_req(MD_SCHED, 16'h0004, 16'h0001, 64'd0, 8'sd1);
        for (int i = 0; i < 12; i++)
            add_req(MD_SCHED, 16'h0100 + 16'(i), 16'h00A0 + 16'(i % 3),
                    64'd6 + 64'(i % 4), 8'(i * 17 - 100));
        // full queue, then past tick while full
        add_req(MD_SCHED, 16'h0200, 16'h0002, 64'd7, 8'sd3);
        add_req(MD_SCHED, 16'h0201, 16'h0002, 64'd1, 8'sd3);
        add_req(MD_DEL_NAME, 16'h0000, 16'h00A0, 64'd0, 8'sd0);
        add_req(MD_DEL_ID, 16'hFFFF, 16'h0000, 64'd0, 8'sd0);
        add_req(MD_POP, 16'h0000, 16'h0000, 64'd0, 8'sd0);
        add_req(MD_POP, 16'h0000, 16'h0000, 64'd0, 8'sd0);
        add_req(MD_DEL_NAME, 16'h0000, 16'hFFFF, 64'd0, 8'sd0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // random batches, ticks set around the current tick of the shadow
        sent = 0;
        while (sent < RAND_ITEMS) begin
            while (req_backlog.size() != 0)
                @(negedge i_clk);
            base  = shadow_now;
            est   = shadow_count;
            batch = quiet_span ? 40 : $urandom_range(1, 24);
            for (int k = 0; k < batch; k++) begin
                pick = $urandom_range(0, 99);
                if (est >= 14)
                    m = (pick < 45) ? MD_SCHED : (pick < 75) ? MD_POP :
                        (pick < 88) ? MD_DEL_ID : MD_DEL_NAME;
                else if (est < 3)
                    m = (pick < 75) ? MD_SCHED : (pick < 85) ? MD_POP :
                        (pick < 93) ? MD_DEL_ID : MD_DEL_NAME;
                else
                    m = (pick < 55) ? MD_SCHED : (pick < 78) ? MD_POP :
                        (pick < 89) ? MD_DEL_ID : MD_DEL_NAME;
                id = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
                nm = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
                if ($urandom_range(0, 1) == 0) begin
                    pr = 8'($urandom);
                end else begin
                    pr = 8'($urandom_range(0, 2));
                    pr = pr - 8'sd1;
                end
                if ($urandom_range(0, 99) < 8 && base >= 4)
                    tk = base - 64'($urandom_range(1, 4));
                else
                    tk = base + 64'($urandom_range(0, 6)) + 64'(k / 4);
                if (m == MD_SCHED && est < CAPACITY)
                    est++;
                else if (m == MD_POP && est > 0)
                    est--;
                else if (m != MD_SCHED && est > 0 && $urandom_range(0, 1) == 0)
                    est--;
                add_req(m, id, nm, tk, pr);
            end
            sent += batch;
        end

        // drain
        while (req_backlog.size() != 0)
            @(posedge i_clk);
        while (result_due_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
